// File: design/kact_pkg.sv
package kact_pkg;

  // token kinds as they appear on the result channel
  typedef enum logic [3:0] {
    KIND_IDENT    = 4'd0,
    KIND_KEYWORD  = 4'd1,
    KIND_ASSIGN   = 4'd2,
    KIND_PLUS     = 4'd3,
    KIND_MINUS    = 4'd4,
    KIND_MULTIPLY = 4'd5,
    KIND_DIVIDE   = 4'd6,
    KIND_LPAREN   = 4'd7,
    KIND_RPAREN   = 4'd8,
    KIND_EOL      = 4'd9
  } kind_e;

  // kind of the pending run
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_DIGIT = 2'd1,
    MODE_ALPHA = 2'd2
  } mode_e;

  localparam int unsigned KwFirstLen  = 10;
  localparam int unsigned KwSecondLen = 5;
  localparam int unsigned QueueDepth  = 4;

  // one result beat
  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic        last;
  } tok_t;

  // the up to two results of one character, in delivery order
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

  // first keyword, "summonsoul"
  function automatic logic [7:0] kw_first_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "s";
      4'd1:    ch = "u";
      4'd2:    ch = "m";
      4'd3:    ch = "m";
      4'd4:    ch = "o";
      4'd5:    ch = "n";
      4'd6:    ch = "s";
      4'd7:    ch = "o";
      4'd8:    ch = "u";
      4'd9:    ch = "l";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // second keyword, "chant"
  function automatic logic [7:0] kw_second_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "h";
      4'd2:    ch = "a";
      4'd3:    ch = "n";
      4'd4:    ch = "t";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  // one-character operator tokens; identifier kind means none
  function automatic kind_e single_kind(input logic [7:0] c);
    kind_e k;
    unique case (c)
      "=":     k = KIND_ASSIGN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_MULTIPLY;
      "/":     k = KIND_DIVIDE;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ";":     k = KIND_EOL;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

// File: design/kact_lexer.sv
module kact_lexer #(
  parameter int unsigned OFFSET_BITS   = 16,
  parameter int unsigned MAX_TOKEN_LEN = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_i,
  input  logic                eos_i,
  output kact_pkg::tok_pair_t pair_o
);
  import kact_pkg::*;

  localparam int unsigned LenBits = $clog2(MAX_TOKEN_LEN + 1);

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LenBits-1:0]     len_q, len_d;
  logic                   m1_q, m1_d;
  logic                   m2_q, m2_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  logic  dig, alp, extend;
  kind_e sk;
  tok_t  tok_a, tok_b, tok_c, tok_2;
  logic  a_vld, b_vld, c_vld, second_vld;

  // narrowing helpers for the result fields
  function automatic logic [15:0] start_out(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] w;
    w = (OFFSET_BITS + 16)'(v);
    return w[15:0];
  endfunction

  function automatic logic [7:0] len_out(input logic [LenBits-1:0] v);
    logic [LenBits+7:0] w;
    w = (LenBits + 8)'(v);
    return w[7:0];
  endfunction

  // character classes
  assign dig = is_digit(char_i);
  assign alp = is_alpha(char_i);
  assign sk  = single_kind(char_i);

  assign extend = ((mode_q == MODE_DIGIT) && dig) ||
                  ((mode_q == MODE_ALPHA) && (dig || alp));

  // run finished by this character
  always_comb begin
    a_vld       = !extend && (mode_q != MODE_NONE);
    tok_a.kind  = ((mode_q == MODE_ALPHA) &&
                   ((m1_q && (len_q == LenBits'(KwFirstLen))) ||
                    (m2_q && (len_q == LenBits'(KwSecondLen)))))
                  ? KIND_KEYWORD : KIND_IDENT;
    tok_a.start  = start_out(start_q);
    tok_a.length = len_out(len_q);
    tok_a.last   = 1'b0;
  end

  // pending run after this character, before the end-of-source flush
  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    m1_d    = m1_q;
    m2_d    = m2_q;
    b_vld   = 1'b0;
    if (extend) begin
      if (len_q >= LenBits'(MAX_TOKEN_LEN)) begin
        len_d = LenBits'(MAX_TOKEN_LEN);
        m1_d  = 1'b0;
        m2_d  = 1'b0;
      end else begin
        m1_d  = m1_q && (len_q < LenBits'(KwFirstLen)) &&
                (kw_first_char(len_q[3:0]) == char_i);
        m2_d  = m2_q && (len_q < LenBits'(KwSecondLen)) &&
                (kw_second_char(len_q[3:0]) == char_i);
        len_d = len_q + LenBits'(1);
      end
    end else if (dig || alp) begin
      mode_d  = dig ? MODE_DIGIT : MODE_ALPHA;
      start_d = off_q;
      len_d   = LenBits'(1);
      m1_d    = (char_i == kw_first_char(4'd0));
      m2_d    = (char_i == kw_second_char(4'd0));
    end else begin
      mode_d = MODE_NONE;
      len_d  = '0;
      m1_d   = 1'b0;
      m2_d   = 1'b0;
      b_vld  = (sk != KIND_IDENT);
    end
  end

  // operator token and end-of-source flush
  always_comb begin
    tok_b.kind   = sk;
    tok_b.start  = start_out(off_q);
    tok_b.length = 8'd1;
    tok_b.last   = 1'b1;

    c_vld        = eos_i && (mode_d != MODE_NONE);
    tok_c.kind   = ((mode_d == MODE_ALPHA) &&
                    ((m1_d && (len_d == LenBits'(KwFirstLen))) ||
                     (m2_d && (len_d == LenBits'(KwSecondLen)))))
                   ? KIND_KEYWORD : KIND_IDENT;
    tok_c.start  = start_out(start_d);
    tok_c.length = len_out(len_d);
    tok_c.last   = 1'b1;
  end

  // order the results: finished run first
  always_comb begin
    second_vld  = b_vld || c_vld;
    tok_2       = b_vld ? tok_b : tok_c;
    pair_o      = '0;
    if (a_vld) begin
      pair_o.first      = tok_a;
      pair_o.first.last = !second_vld;
      pair_o.second     = tok_2;
      pair_o.count      = second_vld ? 2'd2 : 2'd1;
    end else begin
      pair_o.first  = tok_2;
      pair_o.second = tok_2;
      pair_o.count  = second_vld ? 2'd1 : 2'd0;
    end
    pair_o.count = accept_i ? pair_o.count : 2'd0;
  end

  assign off_d = eos_i ? '0 : off_q + OFFSET_BITS'(1);

  // run and offset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      start_q <= '0;
      len_q   <= '0;
      m1_q    <= 1'b0;
      m2_q    <= 1'b0;
      off_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= eos_i ? MODE_NONE : mode_d;
      start_q <= start_d;
      len_q   <= eos_i ? '0 : len_d;
      m1_q    <= eos_i ? 1'b0 : m1_d;
      m2_q    <= eos_i ? 1'b0 : m2_d;
      off_q   <= off_d;
    end
  end

endmodule

// File: design/kact_outq.sv
module kact_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kact_pkg::tok_pair_t pair_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output kact_pkg::tok_t      tok_o
);
  import kact_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  tok_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrBits:0]   cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;
  // room for two beats is needed before a character is taken
  assign full_o  = (cnt_q > (PtrBits + 1)'(QueueDepth - 2));

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q + PtrBits'(pair_i.count);
    rd_d  = rd_q + PtrBits'(pop);
    cnt_d = cnt_q + (PtrBits + 1)'(pair_i.count) - (PtrBits + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage, up to two writes a cycle
  always_ff @(posedge clk_i) begin
    if (pair_i.count != 2'd0) begin
      mem_q[wr_q] <= pair_i.first;
    end
    if (pair_i.count == 2'd2) begin
      mem_q[wr_q + PtrBits'(1)] <= pair_i.second;
    end
  end

endmodule

// File: design/keyword_aware_char_tokenizer.sv
// Character tokenizer with keyword marking.
// Input channel: one source character per beat (char_code_i, end_of_source_i)
// under in_valid_i / in_stall_o. Output channel: one token per beat
// (token_kind_o, token_start_o, token_length_o, last_of_run_o) under
// out_valid_o / out_stall_i; last_of_run_o marks the final token a character
// caused. A character yields zero, one or two tokens.
// Tokens are registered in the output queue before they reach the port.
// One character per cycle while each yields at most one token and the
// receiver does not stall; a character with two tokens leaves its second
// token in a four-beat output queue. in_stall_o rises when the queue holds
// three or more tokens, i.e. it cannot absorb a two-token character.
// A stalled receiver holds the current token on the port unchanged; the
// queue then fills and stalls the input.
// Reset clears the pending run, the character offset and the queue; the
// first character after reset, or after an end-of-source beat, is offset 0.
module keyword_aware_char_tokenizer #(
  parameter int unsigned OFFSET_BITS   = 16,
  parameter int unsigned MAX_TOKEN_LEN = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [7:0]  token_length_o,
  output logic        last_of_run_o
);
  import kact_pkg::*;

  logic      accept;
  logic      full;
  tok_pair_t pair;
  tok_t      head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // classification and run tracking
  kact_lexer #(
    .OFFSET_BITS  (OFFSET_BITS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (char_code_i),
    .eos_i   (end_of_source_i),
    .pair_o  (pair)
  );

  // result queue
  kact_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .tok_o  (head)
  );

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign last_of_run_o  = head.last;

endmodule

// File: design/kact_checker.sv
module kact_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_code_i,
  input logic        end_of_source_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [15:0] token_start_o,
  input logic [7:0]  token_length_o,
  input logic        last_of_run_o
);
  import kact_pkg::*;

  // a stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_start_o) && $stable(token_length_o) && $stable(last_of_run_o))
    else $error("stalled token changed");

  // kinds stay within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= KIND_EOL)
    else $error("undefined token kind");

  // operator tokens are one character long
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o >= KIND_ASSIGN |-> token_length_o == 8'd1)
    else $error("operator token length not one");

  // keywords have exactly a keyword's length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_KEYWORD |->
      token_length_o == 8'(KwFirstLen) || token_length_o == 8'(KwSecondLen))
    else $error("keyword with wrong length");

  // only a run token could ever show a zero length field, and only by
  // the length wrapping at the field width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_length_o != 8'd0 || token_kind_o == KIND_IDENT)
    else $error("non-identifier token of zero length");

endmodule

bind keyword_aware_char_tokenizer kact_checker u_kact_checker (.*);
